@@ rtl/core/aes128_pkg.sv @@
// Package with AES-128 types, S-box tables and GF(2^8) helper functions.
`default_nettype none
package aes128_pkg;

  localparam int BlockWidth = 128;
  localparam int HalfWidth = 64;
  localparam int NumRounds = 10;
  localparam int CfgIdxWidth = 1;

  typedef logic [BlockWidth-1:0] block_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  // One round's control and data as it moves down the pipeline.
  typedef struct packed {
    logic   valid;
    logic   decrypt;
    block_t state;
    block_t round_key;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tab[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] tab [256];
    tab = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return tab[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits at bits 127-8i down to 120-8i.
  function automatic logic [7:0] get_byte(input block_t b, input int i);
    return b[BlockWidth-1-8*i -: 8];
  endfunction

  // Next round key forward; rc is the round constant of the new key.
  function automatic block_t key_fwd(input block_t p, input logic [7:0] rc);
    block_t q;
    logic [31:0] t;
    t = {sbox(get_byte(p, 13)) ^ rc, sbox(get_byte(p, 14)),
         sbox(get_byte(p, 15)), sbox(get_byte(p, 12))};
    q[127:96] = p[127:96] ^ t;
    q[95:64]  = p[95:64] ^ q[127:96];
    q[63:32]  = p[63:32] ^ q[95:64];
    q[31:0]   = p[31:0] ^ q[63:32];
    return q;
  endfunction

  // Previous round key from key q; rc is the constant used to make q.
  function automatic block_t key_bwd(input block_t q, input logic [7:0] rc);
    block_t p;
    logic [31:0] t;
    p[31:0]  = q[31:0] ^ q[63:32];
    p[63:32] = q[63:32] ^ q[95:64];
    p[95:64] = q[95:64] ^ q[127:96];
    t = {sbox(p[23:16]) ^ rc, sbox(p[15:8]), sbox(p[7:0]), sbox(p[31:24])};
    p[127:96] = q[127:96] ^ t;
    return p;
  endfunction

  function automatic logic [7:0] rcon(input int r);
    logic [7:0] c;
    c = 8'h01;
    for (int k = 1; k < r; k++) c = xt(c);
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/aes128_round.sv @@
// One registered AES round: encrypt or decrypt round plus round key step.
`default_nettype none
module aes128_round #(
  parameter int Round = 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire aes128_pkg::stage_t in_stage,
  output aes128_pkg::stage_t      out_stage
);
  import aes128_pkg::*;

  localparam logic [7:0] EncRc = rcon(Round);
  localparam logic [7:0] DecRc = rcon(NumRounds + 1 - Round);
  localparam bit LastRound = (Round == NumRounds);

  block_t key_next;
  block_t state_next;
  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] mx [16];
  logic [7:0] src [16];

  always_comb begin
    key_next = in_stage.decrypt ? key_bwd(in_stage.round_key, DecRc)
                                : key_fwd(in_stage.round_key, EncRc);
    for (int i = 0; i < 16; i++) src[i] = get_byte(in_stage.state, i);
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (in_stage.decrypt) begin
          sr[r + 4 * ((c + r) % 4)] = inv_sbox(src[r + 4 * c]);
        end else begin
          sr[r + 4 * c] = sbox(src[r + 4 * ((c + r) % 4)]);
        end
      end
    end
    // Decrypt adds the key before the inverse column mix.
    for (int i = 0; i < 16; i++) begin
      sb[i] = in_stage.decrypt ? (sr[i] ^ get_byte(key_next, i)) : sr[i];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [7:0] a0, a1, a2, a3;
        a0 = sb[4 * c + r];
        a1 = sb[4 * c + (r + 1) % 4];
        a2 = sb[4 * c + (r + 2) % 4];
        a3 = sb[4 * c + (r + 3) % 4];
        if (in_stage.decrypt) begin
          // 14*a0 ^ 11*a1 ^ 13*a2 ^ 9*a3
          mx[4 * c + r] = xt(a0 ^ a1) ^ xt(xt(a0 ^ a2)) ^ xt(xt(xt(a0 ^ a1 ^ a2 ^ a3)))
                          ^ a1 ^ a2 ^ a3;
        end else begin
          mx[4 * c + r] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (LastRound) begin
        state_next[BlockWidth-1-8*i -: 8] = in_stage.decrypt ? sb[i]
                                            : (sb[i] ^ get_byte(key_next, i));
      end else if (in_stage.decrypt) begin
        state_next[BlockWidth-1-8*i -: 8] = mx[i];
      end else begin
        state_next[BlockWidth-1-8*i -: 8] = mx[i] ^ get_byte(key_next, i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else if (advance) begin
      out_stage.valid <= in_stage.valid;
    end
    if (advance) begin
      out_stage.decrypt   <= in_stage.decrypt;
      out_stage.state     <= state_next;
      out_stage.round_key <= key_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/aes128_block_cipher_unit.sv @@
// Top level of the pipelined AES-128 encrypt and decrypt unit.
//
// Usage: load the key through the write port (index 0 writes key bytes 0..7,
// index 1 writes bytes 8..15) while the unit holds no requests. Then send
// requests on the in channel: cmd 0 encrypts, cmd 1 decrypts. Every request
// gives one result block on the out channel, in order.
// The data path is eleven register stages: an input stage that adds the
// first round key (for decryption the last round key), then one stage per
// round. Throughput is one request per cycle while the key schedule is idle;
// the pipeline advances whenever the output stage is empty or being taken.
// The last round key for decryption comes from a key schedule that runs one
// round per cycle. It restarts on each key write and on reset, and in_ready
// stays low while it runs.
// When the receiver stalls the whole pipeline holds; nothing is lost or
// repeated, and in_ready also drops while the output result waits.
// Reset clears the stage valid bits and both key registers to zero.
`default_nettype none
module aes128_block_cipher_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [63:0] block_high,
  input  wire logic [63:0] block_low,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      result_high,
  output logic [63:0]      result_low
);
  import aes128_pkg::*;

  logic [63:0] key_high;
  logic [63:0] key_low;
  block_t key_written;
  block_t sched_key;
  logic [7:0] sched_rc;
  logic [3:0] sched_count;
  logic sched_busy;
  logic advance;
  stage_t stages [NumRounds+1];
  stage_t entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The full key as it stands once this cycle's write has landed.
  always_comb begin
    if (cfg_index == REG_KEY_HIGH) key_written = {cfg_data, key_low};
    else key_written = {key_high, cfg_data};
  end

  // Forward key schedule, one round per cycle, ending on the last round key.
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_busy  <= 1'b1;
      sched_count <= '0;
      sched_rc    <= 8'h01;
      sched_key   <= '0;
    end else if (cfg_we) begin
      sched_busy  <= 1'b1;
      sched_count <= '0;
      sched_rc    <= 8'h01;
      sched_key   <= key_written;
    end else if (sched_busy) begin
      sched_key   <= key_fwd(sched_key, sched_rc);
      sched_rc    <= xt(sched_rc);
      sched_count <= sched_count + 4'd1;
      sched_busy  <= (sched_count != 4'(NumRounds - 1));
    end
  end

  assign advance  = !stages[NumRounds].valid || out_ready;
  assign in_ready = advance && !sched_busy;

  always_comb begin
    entry.valid     = in_valid && !sched_busy;
    entry.decrypt   = (cmd == CMD_DECRYPT);
    entry.round_key = entry.decrypt ? sched_key : {key_high, key_low};
    entry.state     = {block_high, block_low} ^ entry.round_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stages[0].valid <= 1'b0;
    end else if (advance) begin
      stages[0].valid <= entry.valid;
    end
    if (advance) begin
      stages[0].decrypt   <= entry.decrypt;
      stages[0].state     <= entry.state;
      stages[0].round_key <= entry.round_key;
    end
  end

  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes128_round #(.Round(g)) u_round (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .in_stage (stages[g-1]),
      .out_stage(stages[g])
    );
  end

  assign out_valid   = stages[NumRounds].valid;
  assign result_high = stages[NumRounds].state[127:64];
  assign result_low  = stages[NumRounds].state[63:0];

endmodule
`default_nettype wire

@@ rtl/core/aes128_checker.sv @@
// Port-level checker for the AES-128 unit, bound to the top level.
`default_nettype none
module aes128_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] result_high,
  input wire logic [63:0] result_low
);
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_high) && $stable(result_low))
    else $error("stalled result changed");
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");
endmodule

bind aes128_block_cipher_unit aes128_checker u_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .result_high(result_high), .result_low(result_low)
);
`default_nettype wire

@@ test/aes128_result_checker.sv @@
// Checker for the AES-128 unit: tracks the key, predicts each result, compares in order.
`timescale 1ns / 1ps
module aes128_result_checker (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire aes128_pkg::cfg_reg_t cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire aes128_pkg::cmd_t     cmd,
  input  wire logic [63:0]          block_high,
  input  wire logic [63:0]          block_low,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic [63:0]          result_high,
  input  wire logic [63:0]          result_low,
  output int                        fail_count,
  output int                        pending
);
  import aes128_pkg::*;

  logic [7:0] sbox_tab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  logic [7:0] inv_sbox_tab [256];

  logic [127:0] cipher_key;
  logic [127:0] expected_blocks [$];

  initial begin
    for (int i = 0; i < 256; i++) inv_sbox_tab[sbox_tab[i]] = i[7:0];
  end

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [127:0] sub_state(input logic [127:0] x, input logic inv);
    logic [127:0] y;
    for (int i = 0; i < 16; i++)
      y[127-8*i -: 8] = inv ? inv_sbox_tab[x[127-8*i -: 8]] : sbox_tab[x[127-8*i -: 8]];
    return y;
  endfunction

  // Row r rotates left by r columns going forward, right going back.
  function automatic logic [127:0] shift_state(input logic [127:0] x, input logic inv);
    logic [127:0] y;
    int src, dst;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          src = r + 4 * c;
          dst = r + 4 * ((c + r) & 3);
        end else begin
          dst = r + 4 * c;
          src = r + 4 * ((c + r) & 3);
        end
        y[127-8*dst -: 8] = x[127-8*src -: 8];
      end
    return y;
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] x, input logic inv);
    logic [7:0] fwd_m [4];
    logic [7:0] inv_m [4];
    logic [127:0] y;
    logic [7:0] acc;
    fwd_m = '{8'd2, 8'd3, 8'd1, 8'd1};
    inv_m = '{8'd14, 8'd11, 8'd13, 8'd9};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int j = 0; j < 4; j++)
          acc = acc ^ gf_mul(x[127-8*(4*c+j) -: 8],
                             inv ? inv_m[(j - r + 4) & 3] : fwd_m[(j - r + 4) & 3]);
        y[127-8*(4*c+r) -: 8] = acc;
      end
    return y;
  endfunction

  function automatic logic [127:0] aes_transform(input logic [127:0] key,
                                                 input logic [127:0] din, input logic inv);
    logic [127:0] rk [11];
    logic [127:0] s;
    logic [7:0] rc;
    logic [31:0] t;
    rk[0] = key;
    rc = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      t = {sbox_tab[rk[r-1][23:16]] ^ rc, sbox_tab[rk[r-1][15:8]],
           sbox_tab[rk[r-1][7:0]], sbox_tab[rk[r-1][31:24]]};
      rk[r][127:96] = rk[r-1][127:96] ^ t;
      rk[r][95:64]  = rk[r-1][95:64] ^ rk[r][127:96];
      rk[r][63:32]  = rk[r-1][63:32] ^ rk[r][95:64];
      rk[r][31:0]   = rk[r-1][31:0] ^ rk[r][63:32];
      rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
    end
    if (!inv) begin
      s = din ^ rk[0];
      for (int r = 1; r <= 10; r++) begin
        s = shift_state(sub_state(s, 1'b0), 1'b0);
        if (r != 10) s = mix_state(s, 1'b0);
        s = s ^ rk[r];
      end
    end else begin
      s = din ^ rk[10];
      for (int r = 9; r >= 0; r--) begin
        s = sub_state(shift_state(s, 1'b1), 1'b1) ^ rk[r];
        if (r != 0) s = mix_state(s, 1'b1);
      end
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst) begin
      cipher_key <= '0;
      expected_blocks.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready)
        expected_blocks.push_back(aes_transform(cipher_key, {block_high, block_low},
                                                cmd == CMD_DECRYPT));
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("result with no request", result_high, 64'h0);
        end else begin
          want = expected_blocks.pop_front();
          if (result_high !== want[127:64]) report_mismatch("result_high", result_high,
                                                            want[127:64]);
          if (result_low !== want[63:0]) report_mismatch("result_low", result_low, want[63:0]);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_KEY_HIGH) cipher_key[127:64] <= cfg_data;
        else cipher_key[63:0] <= cfg_data;
      end
    end
    pending <= expected_blocks.size();
  end

endmodule

@@ test/tb.sv @@
// Top of the AES-128 unit testbench: clock, reset, key loads, requests and verdict.
`timescale 1ns / 1ps
module tb;
  import aes128_pkg::*;

  // The run is bounded by this many cycles; a correct run needs far fewer.
  localparam int CycleLimit = 400000;
  // Pipeline depth plus margin, waited out before key writes and at the end.
  localparam int DrainCycles = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  cmd_t        cmd = CMD_ENCRYPT;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result_high;
  logic [63:0] result_low;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  // When set, both sides run without gaps for a while.
  logic        burst_mode = 1'b0;

  always #1 clk = ~clk;

  aes128_block_cipher_unit dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready, .cmd,
    .block_high, .block_low, .out_valid, .out_ready, .result_high, .result_low
  );

  aes128_result_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready, .cmd,
    .block_high, .block_low, .out_valid, .out_ready, .result_high, .result_low,
    .fail_count, .pending
  );

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Presents one request and returns at the falling edge after it is taken,
  // with valid still high so that a back-to-back request needs no toggle.
  task automatic send_request(input cmd_t op, input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    block_high <= hi;
    block_low  <= lo;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Key writes happen only with the pipeline empty and settled.
  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_HIGH;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_index <= REG_KEY_LOW;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  // Random requests: mostly random data, with some all-zero and all-one halves.
  task automatic send_random(input int count);
    logic [63:0] hi, lo;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 40) == 0) burst_mode <= ~burst_mode;
      hi = rand_word();
      lo = rand_word();
      case ($urandom_range(0, 15))
        0: hi = '0;
        1: lo = '1;
        default: ;
      endcase
      send_request($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT, hi, lo);
    end
  endtask

  // The receiver stalls a random number of cycles, none in burst mode, before taking each result.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with the standard example key: the published test vector
    // both ways, the all-zero and all-one blocks each way, and two end-bit blocks.
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_request(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_request(CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_request(CMD_ENCRYPT, '0, '0);
    send_request(CMD_DECRYPT, '0, '0);
    send_request(CMD_ENCRYPT, '1, '1);
    send_request(CMD_DECRYPT, '1, '1);
    send_request(CMD_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
    send_request(CMD_DECRYPT, 64'h0000000000000001, 64'h8000000000000000);

    // Extreme keys, the first two with two directed blocks, all with random blocks, then random keys.
    load_key('0, '0);
    send_request(CMD_ENCRYPT, '0, '0);
    send_request(CMD_DECRYPT, '1, '1);
    send_random(60);
    load_key('1, '1);
    send_request(CMD_ENCRYPT, '1, '1);
    send_request(CMD_DECRYPT, '0, '0);
    send_random(60);
    load_key('0, '1);
    send_random(60);
    for (int k = 0; k < 6; k++) begin
      load_key(rand_word(), rand_word());
      send_random(85);
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
